// ----- rtl/bech32_checksum_engine_assert.svh -----
// Assertion macros shared by the checksum engine RTL.
`ifndef BECH32_CHECKSUM_ENGINE_ASSERT_SVH
`define BECH32_CHECKSUM_ENGINE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle, sampled on clk outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// The condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ----- rtl/bcc_pkg.sv -----
// Types, constants and GF(32) helper functions of the checksum engine.
package bcc_pkg;

	typedef struct packed {
		logic       req_type;
		logic [7:0] value;
		logic       last;
	} req_t;

	typedef struct packed {
		logic [4:0] symbol;
		logic [1:0] status;
		logic       result_last;
	} res_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		logic       is_data;
		logic       mode;
		logic [4:0] sym;
		logic [4:0] low;
		logic       bad;
		logic       last;
	} cmd_t;

	localparam logic [1:0] ST_SYMBOL  = 2'd0;
	localparam logic [1:0] ST_BECH32  = 2'd1;
	localparam logic [1:0] ST_BECH32M = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic MODE_CREATE = 1'b0;
	localparam logic MODE_VERIFY = 1'b1;

	localparam logic [29:0] GEN0 = 30'h3b6a57b2;
	localparam logic [29:0] GEN1 = 30'h26508e6d;
	localparam logic [29:0] GEN2 = 30'h1ea119fa;
	localparam logic [29:0] GEN3 = 30'h3d4233dd;
	localparam logic [29:0] GEN4 = 30'h2a1462b3;
	localparam logic [29:0] REM_ONE = 30'h1;
	localparam logic [29:0] BECH32M_CONST = 30'h2bc830a3;

	function automatic logic [29:0] gf_step(input logic [29:0] r, input logic [4:0] s);
		logic [4:0]  top;
		logic [29:0] n;
		top = r[29:25];
		n = {r[24:0], s};
		if (top[0]) n = n ^ GEN0;
		if (top[1]) n = n ^ GEN1;
		if (top[2]) n = n ^ GEN2;
		if (top[3]) n = n ^ GEN3;
		if (top[4]) n = n ^ GEN4;
		return n;
	endfunction

	// Returns {valid, index} of an ASCII character in the address alphabet.
	function automatic logic [5:0] charset_index(input logic [7:0] ch);
		logic [5:0] r;
		case (ch)
			"q": r = {1'b1, 5'd0};
			"p": r = {1'b1, 5'd1};
			"z": r = {1'b1, 5'd2};
			"r": r = {1'b1, 5'd3};
			"y": r = {1'b1, 5'd4};
			"9": r = {1'b1, 5'd5};
			"x": r = {1'b1, 5'd6};
			"8": r = {1'b1, 5'd7};
			"g": r = {1'b1, 5'd8};
			"f": r = {1'b1, 5'd9};
			"2": r = {1'b1, 5'd10};
			"t": r = {1'b1, 5'd11};
			"v": r = {1'b1, 5'd12};
			"d": r = {1'b1, 5'd13};
			"w": r = {1'b1, 5'd14};
			"0": r = {1'b1, 5'd15};
			"s": r = {1'b1, 5'd16};
			"3": r = {1'b1, 5'd17};
			"j": r = {1'b1, 5'd18};
			"n": r = {1'b1, 5'd19};
			"5": r = {1'b1, 5'd20};
			"4": r = {1'b1, 5'd21};
			"k": r = {1'b1, 5'd22};
			"h": r = {1'b1, 5'd23};
			"c": r = {1'b1, 5'd24};
			"e": r = {1'b1, 5'd25};
			"6": r = {1'b1, 5'd26};
			"m": r = {1'b1, 5'd27};
			"u": r = {1'b1, 5'd28};
			"a": r = {1'b1, 5'd29};
			"7": r = {1'b1, 5'd30};
			"l": r = {1'b1, 5'd31};
			default: r = 6'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/bcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bcc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 83
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/bcc_front.sv -----
// Front end: takes requests and classifies them into commands for the back end.
module bcc_front (
	input  logic          mode,
	input  logic          req_valid,
	output logic          req_ready,
	input  bcc_pkg::req_t req,
	input  logic          full,
	output logic          push,
	output bcc_pkg::cmd_t cmd
);
	import bcc_pkg::*;

	logic [5:0] cs;

	assign cs        = charset_index(req.value);
	assign req_ready = !full;
	assign push      = req_valid && !full;

	always_comb begin
		cmd.is_data = req.req_type;
		cmd.mode    = mode;
		cmd.low     = req.value[4:0];
		cmd.last    = req.last;
		if (!req.req_type) begin
			// A prefix character feeds its high three bits first.
			cmd.sym = {2'b00, req.value[7:5]};
			cmd.bad = 1'b0;
		end else if (mode == MODE_CREATE) begin
			cmd.sym = req.value[4:0];
			cmd.bad = req.value[7:5] != 3'd0;
		end else begin
			cmd.sym = cs[4:0];
			cmd.bad = !cs[5];
		end
	end

endmodule

// ----- rtl/bcc_fifo.sv -----
// Short command queue between the front and back ends.
module bcc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bcc_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output bcc_pkg::cmd_t head
);
	import bcc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = cnt_q == CW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/bcc_back.sv -----
// Back end: remainder update, prefix buffer walk and result sequencing.
module bcc_back #(
	parameter int PREFIX_MAX = 83
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bcc_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	input  logic          res_ready,
	output bcc_pkg::res_t res
);
	import bcc_pkg::*;

	localparam int CW = $clog2(PREFIX_MAX + 1);
	localparam int AW = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CLOSE = 3'b010,
		S_OUT   = 3'b100
	} state_t;

	state_t        state_q;
	logic [29:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          in_data_q;
	logic          err_q;
	logic [CW-1:0] idx_q;
	logic          rd_pend_q;
	logic [29:0]   sh_q;
	logic [2:0]    nleft_q;
	logic [1:0]    st_q;
	logic          out_valid_q;
	res_t          out_q;

	logic [29:0]   base_rem;
	logic [CW-1:0] base_cnt;
	logic          base_err;
	logic          room;
	logic [29:0]   pre_rem;
	logic [29:0]   dat_rem;
	logic          dat_err;
	logic [29:0]   close_rem;
	logic [29:0]   walk_rem;
	logic [1:0]    ver_status;
	logic          need_close;
	logic          ram_we;
	logic          rd_en;
	logic [4:0]    rd_data;
	logic          out_load;

	// A prefix character after the data phase begins a fresh message.
	assign base_rem  = in_data_q ? REM_ONE : rem_q;
	assign base_cnt  = in_data_q ? '0 : cnt_q;
	assign base_err  = in_data_q ? 1'b0 : err_q;
	assign room      = base_cnt < CW'(PREFIX_MAX);
	assign pre_rem   = room ? gf_step(base_rem, cmd.sym) : base_rem;
	assign dat_rem   = cmd.bad ? rem_q : gf_step(rem_q, cmd.sym);
	assign dat_err   = err_q | cmd.bad;
	assign close_rem = gf_step(cmd.is_data ? rem_q : pre_rem, 5'd0);
	assign walk_rem  = gf_step(rem_q, rd_data);

	assign ver_status = (dat_rem == REM_ONE) ? ST_BECH32 :
		(dat_rem == BECH32M_CONST) ? ST_BECH32M : ST_INVALID;

	// A data command that finds the prefix still open waits in the queue for the walk.
	assign need_close = cmd_valid && cmd.is_data && !in_data_q;
	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid && !need_close;
	assign ram_we     = cmd_pop && !cmd.is_data && room;
	assign rd_en      = (state_q == S_CLOSE) && (idx_q < cnt_q);
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || res_ready);

	assign res_valid = out_valid_q;
	assign res       = out_q;

	bcc_ram #(
		.WIDTH(5),
		.DEPTH(PREFIX_MAX)
	) u_prefix_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(base_cnt[AW-1:0]),
		.wdata(cmd.low),
		.re   (rd_en),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (st_q != ST_SYMBOL) begin
				out_q.symbol      <= 5'd0;
				out_q.status      <= st_q;
				out_q.result_last <= 1'b1;
			end else begin
				out_q.symbol      <= sh_q[29:25];
				out_q.status      <= ST_SYMBOL;
				out_q.result_last <= nleft_q == 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rem_q       <= REM_ONE;
			cnt_q       <= '0;
			in_data_q   <= 1'b0;
			err_q       <= 1'b0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			sh_q        <= '0;
			nleft_q     <= '0;
			st_q        <= ST_SYMBOL;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (need_close) begin
						rem_q     <= close_rem;
						idx_q     <= '0;
						rd_pend_q <= 1'b0;
						state_q   <= S_CLOSE;
					end else if (cmd_pop && !cmd.is_data) begin
						in_data_q <= 1'b0;
						cnt_q     <= room ? base_cnt + 1'b1 : base_cnt;
						err_q     <= base_err | !room;
						if (cmd.last) begin
							rem_q     <= close_rem;
							idx_q     <= '0;
							rd_pend_q <= 1'b0;
							state_q   <= S_CLOSE;
						end else begin
							rem_q <= pre_rem;
						end
					end else if (cmd_pop) begin
						if (cmd.last) begin
							if (dat_err) begin
								st_q    <= ST_INVALID;
								nleft_q <= 3'd1;
							end else if (cmd.mode == MODE_CREATE) begin
								st_q    <= ST_SYMBOL;
								sh_q    <= dat_rem ^ REM_ONE;
								nleft_q <= 3'd6;
							end else begin
								st_q    <= ver_status;
								nleft_q <= 3'd1;
							end
							rem_q     <= REM_ONE;
							cnt_q     <= '0;
							in_data_q <= 1'b0;
							err_q     <= 1'b0;
							state_q   <= S_OUT;
						end else begin
							rem_q <= dat_rem;
							err_q <= dat_err;
						end
					end
				end
				S_CLOSE: begin
					if (rd_pend_q) begin
						rem_q <= walk_rem;
					end
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					rd_pend_q <= rd_en;
					if (!rd_en && !rd_pend_q) begin
						in_data_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_load) begin
						sh_q    <= {sh_q[24:0], 5'd0};
						nleft_q <= nleft_q - 1'b1;
						if (st_q != ST_SYMBOL || nleft_q == 3'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/bech32_checksum_engine.sv -----
// Bech32 / Bech32m checksum engine: top level with mode register and checks.
//
// Requests arrive on req_valid/req_ready with a req_t payload: prefix characters
// first (req_type 0, last on the final one), then data items (req_type 1, last on
// the final one). Results leave on res_valid/res_ready as res_t.
// mode_we/mode_wdata write the mode register: 0 creates six checksum symbols,
// 1 verifies an address and returns one status. Write it only while idle.
// Requests pass a classifying front end into a FIFO_DEPTH-entry queue; the back
// end updates the remainder at one request per cycle while idle; a request reaches
// it through the queue register, and a result through the S_OUT state and the
// output register. Closing the prefix walks the buffered low parts through the
// single read port of the prefix RAM. A create message then emits its six
// symbols back to back while the receiver is ready, a verify message one status.
// The front end keeps accepting while the back end walks or emits, until the
// queue fills. When the receiver stalls, the result holds in the output register
// and the back end waits; the queue then fills and req_ready falls.
// Reset clears the remainder to one, the counters, the queue and the mode; the
// prefix RAM needs no clearing since only entries of the current message are read.
module bech32_checksum_engine #(
	parameter int PREFIX_MAX = 83,
	parameter int FIFO_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mode_we,
	input  logic          mode_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  bcc_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output bcc_pkg::res_t res
);
	import bcc_pkg::*;

	`include "bech32_checksum_engine_assert.svh"

	logic mode_q;
	logic full;
	logic push;
	cmd_t push_cmd;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CREATE;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	bcc_front u_front (
		.mode     (mode_q),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.full     (full),
		.push     (push),
		.cmd      (push_cmd)
	);

	bcc_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (full),
		.pop       (cmd_pop),
		.head_valid(cmd_valid),
		.head      (cmd)
	);

	bcc_back #(
		.PREFIX_MAX(PREFIX_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	`ASSERT_NEVER(a_pop_empty, cmd_pop && !cmd_valid)
	`ASSERT_IMPLY(a_status_final, res_valid && res.status != ST_SYMBOL, res.result_last)
	`ASSERT_IMPLY(a_status_no_symbol, res_valid && res.status != ST_SYMBOL, res.symbol == 5'd0)

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the Bech32 checksum engine: directed and random requests.
module tb;
	import bcc_pkg::*;

	localparam int PREFIX_MAX = 83;
	localparam int RANDOM_ITEMS = 200;
	localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
	localparam logic [149:0] GEN_ALL = {GEN4, GEN3, GEN2, GEN1, GEN0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mode_we = 1'b0;
	logic mode_wdata = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	// Expected-behaviour state, kept alongside the block.
	logic        cur_mode;
	logic [29:0] poly_rem;
	logic [4:0]  hrp_low [PREFIX_MAX];
	int          hrp_len;
	bit          in_data;
	bit          err_seen;

	res_t awaited_res [$];
	res_t want;
	int   mismatches = 0;
	int   sent_items = 0;
	int   ready_run = 0;
	bit   no_stall = 1'b0;

	bech32_checksum_engine #(.PREFIX_MAX(PREFIX_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.mode_we(mode_we),
		.mode_wdata(mode_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always #5 clk = ~clk;

	function automatic logic [29:0] polymod_step(logic [29:0] r, logic [4:0] s);
		logic [29:0] n;
		n = {r[24:0], s};
		for (int i = 0; i < 5; i++)
			if (r[25 + i]) n ^= GEN_ALL[30*i +: 30];
		return n;
	endfunction

	function automatic int alphabet_pos(logic [7:0] ch);
		for (int i = 0; i < 32; i++)
			if (ALPHABET[8*(31 - i) +: 8] == ch) return i;
		return -1;
	endfunction

	function automatic void restart_message();
		poly_rem = REM_ONE;
		hrp_len = 0;
		in_data = 1'b0;
		err_seen = 1'b0;
	endfunction

	// A zero symbol separates the high parts from the buffered low parts.
	function automatic void close_hrp();
		poly_rem = polymod_step(poly_rem, 5'd0);
		for (int i = 0; i < hrp_len; i++) poly_rem = polymod_step(poly_rem, hrp_low[i]);
		in_data = 1'b1;
	endfunction

	function automatic void owe(logic [4:0] sym, logic [1:0] st, logic lst);
		res_t e;
		e.symbol = sym;
		e.status = st;
		e.result_last = lst;
		awaited_res.push_back(e);
	endfunction

	function automatic void absorb_request(req_t r);
		int pos;
		logic [29:0] m;
		if (!r.req_type) begin
			if (in_data) restart_message();
			if (hrp_len < PREFIX_MAX) begin
				hrp_low[hrp_len] = r.value[4:0];
				hrp_len++;
				poly_rem = polymod_step(poly_rem, {2'b00, r.value[7:5]});
			end else begin
				err_seen = 1'b1;
			end
			if (r.last) close_hrp();
			return;
		end
		if (!in_data) close_hrp();
		if (cur_mode == MODE_CREATE) begin
			if (r.value > 8'd31) err_seen = 1'b1;
			else poly_rem = polymod_step(poly_rem, r.value[4:0]);
		end else begin
			pos = alphabet_pos(r.value);
			if (pos < 0) err_seen = 1'b1;
			else poly_rem = polymod_step(poly_rem, pos[4:0]);
		end
		if (!r.last) return;
		if (err_seen) begin
			owe(5'd0, ST_INVALID, 1'b1);
		end else if (cur_mode == MODE_CREATE) begin
			m = poly_rem ^ REM_ONE;
			for (int k = 5; k >= 0; k--) owe(m[5*k +: 5], ST_SYMBOL, k == 0);
		end else if (poly_rem == REM_ONE) begin
			owe(5'd0, ST_BECH32, 1'b1);
		end else if (poly_rem == BECH32M_CONST) begin
			owe(5'd0, ST_BECH32M, 1'b1);
		end else begin
			owe(5'd0, ST_INVALID, 1'b1);
		end
		restart_message();
	endfunction

	// Address characters for a prefix and payload, with a checksum for the given constant.
	function automatic void address_chars(input logic [7:0] hrp [$], input logic [4:0] syms [$],
			input logic [29:0] konst, output logic [7:0] chars [$]);
		logic [29:0] r;
		chars = {};
		r = REM_ONE;
		foreach (hrp[i]) r = polymod_step(r, {2'b00, hrp[i][7:5]});
		r = polymod_step(r, 5'd0);
		foreach (hrp[i]) r = polymod_step(r, hrp[i][4:0]);
		foreach (syms[i]) r = polymod_step(r, syms[i]);
		repeat (6) r = polymod_step(r, 5'd0);
		r ^= konst;
		foreach (syms[i]) chars.push_back(ALPHABET[8*(31 - syms[i]) +: 8]);
		for (int k = 5; k >= 0; k--) chars.push_back(ALPHABET[8*(31 - r[5*k +: 5]) +: 8]);
	endfunction

	function automatic int pick_gap();
		int p;
		if (no_stall) return 0;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	task automatic send_req(input logic t, input logic [7:0] v, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{req_type: t, value: v, last: l};
		do @(posedge clk); while (!req_ready);
		absorb_request('{req_type: t, value: v, last: l});
		sent_items++;
	endtask

	task automatic send_prefix(input logic [7:0] hrp [$], input bit close);
		foreach (hrp[i]) send_req(1'b0, hrp[i], close && i == hrp.size() - 1);
	endtask

	task automatic send_data(input logic [7:0] items [$], input bit finish);
		foreach (items[i]) send_req(1'b1, items[i], finish && i == items.size() - 1);
	endtask

	// Lets every result arrive, then leaves time for a prefix close still in flight.
	task automatic settle();
		int waited;
		req_valid <= 1'b0;
		waited = 0;
		while (awaited_res.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_res.size() != 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0d expected results never arrived", awaited_res.size());
			awaited_res = {};
		end
		repeat (150) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 1'b0;
		cur_mode = m;
	endtask

	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (awaited_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: symbol %0d status %0d last %0b",
						res.symbol, res.status, res.result_last);
			end else begin
				want = awaited_res.pop_front();
				if (res.symbol !== want.symbol || res.status !== want.status ||
						res.result_last !== want.result_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp sym %0d st %0d last %0b, got sym %0d st %0d last %0b",
							want.symbol, want.status, want.result_last,
							res.symbol, res.status, res.result_last);
				end
			end
		end
		if (no_stall) begin
			res_ready <= 1'b1;
		end else if (ready_run > 0) begin
			ready_run--;
		end else begin
			res_ready <= ($urandom_range(0, 2) != 0);
			ready_run = pick_gap();
		end
	end

	task automatic test_create_mode();
		logic [7:0] hrp [$];
		logic [7:0] items [$];
		set_mode(MODE_CREATE);
		hrp = '{8'h00, 8'hff};
		items = '{8'd0, 8'd31};
		send_prefix(hrp, 1'b1);
		send_data(items, 1'b1);
		// Data with no prefix at all closes an empty prefix.
		items = '{8'd5};
		send_data(items, 1'b1);
		// The prefix is left open and a wide symbol spoils the message.
		hrp = '{"a", "b"};
		items = '{8'd32, 8'd1};
		send_prefix(hrp, 1'b0);
		send_data(items, 1'b1);
		// A prefix character in the data phase abandons the message.
		hrp = '{"x"};
		items = '{8'd7};
		send_prefix(hrp, 1'b1);
		send_data(items, 1'b0);
		hrp = '{"y"};
		items = '{8'd9};
		send_prefix(hrp, 1'b1);
		send_data(items, 1'b1);
		settle();
	endtask

	task automatic test_verify_mode();
		logic [7:0] hrp [$];
		logic [4:0] syms [$];
		logic [7:0] chars [$];
		set_mode(MODE_VERIFY);
		hrp = '{"a"};
		address_chars(hrp, syms, REM_ONE, chars);
		send_prefix(hrp, 1'b1);
		send_data(chars, 1'b1);
		address_chars(hrp, syms, BECH32M_CONST, chars);
		send_prefix(hrp, 1'b1);
		send_data(chars, 1'b1);
		// Uppercase and non-ASCII characters are outside the alphabet.
		chars = '{"B", 8'd200, "q"};
		send_prefix(hrp, 1'b1);
		send_data(chars, 1'b1);
		chars = '{"q"};
		send_prefix(hrp, 1'b1);
		send_data(chars, 1'b1);
		settle();
	endtask

	task automatic test_overlong_prefix();
		logic [7:0] hrp [$];
		logic [7:0] items [$];
		set_mode(MODE_CREATE);
		repeat (PREFIX_MAX + 3) hrp.push_back(8'($urandom_range(33, 126)));
		items = '{8'd3};
		send_prefix(hrp, 1'b1);
		send_data(items, 1'b1);
		settle();
	endtask

	// Mostly complete messages; otherwise open prefixes, abandoned or prefixless ones.
	task automatic random_message(input bit complete);
		logic [7:0] hrp [$];
		logic [4:0] syms [$];
		logic [7:0] items [$];
		int kind;
		int plen;
		int dlen;
		int pos;
		kind = complete ? 0 : $urandom_range(0, 9);
		no_stall = ($urandom_range(0, 4) == 0);
		plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 8);
		if (kind == 9) plen = 0;
		repeat (plen)
			hrp.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(33, 126)));
		dlen = $urandom_range(0, 12);
		if (cur_mode == MODE_CREATE) begin
			repeat (dlen + 1)
				items.push_back(($urandom_range(0, 24) == 0) ? 8'($urandom_range(32, 255))
					: 8'($urandom_range(0, 31)));
		end else begin
			repeat (dlen) syms.push_back(5'($urandom_range(0, 31)));
			address_chars(hrp, syms, $urandom_range(0, 1) ? REM_ONE : BECH32M_CONST, items);
			pos = $urandom_range(0, items.size() - 1);
			case ($urandom_range(0, 9))
				0: items[pos] = 8'($urandom_range(0, 255));
				1: items[pos] = ALPHABET[8*(31 - ((alphabet_pos(items[pos]) +
					$urandom_range(1, 31)) % 32)) +: 8];
				default: ;
			endcase
		end
		send_prefix(hrp, kind != 7);
		if (kind == 8) begin
			items = items[0:$urandom_range(0, items.size() - 1)];
			if ($urandom_range(0, 2) == 0) items = {};
			send_data(items, 1'b0);
		end else begin
			send_data(items, 1'b1);
		end
	endtask

	task automatic test_random_traffic();
		int target;
		int phase;
		target = sent_items + RANDOM_ITEMS;
		phase = 0;
		while (sent_items < target) begin
			set_mode((phase % 2 == 0) ? MODE_VERIFY : MODE_CREATE);
			repeat ($urandom_range(3, 8)) random_message(1'b0);
			random_message(1'b1);
			no_stall = 1'b0;
			settle();
			phase++;
		end
	endtask

	initial begin
		cur_mode = MODE_CREATE;
		restart_message();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_create_mode();
		test_verify_mode();
		test_overlong_prefix();
		test_random_traffic();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- bech32_checksum_engine.f -----
+incdir+rtl
rtl/bcc_pkg.sv
rtl/bcc_ram.sv
rtl/bcc_front.sv
rtl/bcc_fifo.sv
rtl/bcc_back.sv
rtl/bech32_checksum_engine.sv
tb/sv/tb.sv
